/* design/cht_pkg.sv */
// package for the chained hash table unit
// shared constants and types, no dependencies
package cht_pkg;

   localparam int DEF_BUCKETS       = 256;
   localparam int DEF_ENTRIES       = 1024;
   localparam int DEF_PAYLOAD_WIDTH = 64;

   localparam int KEY_WIDTH   = 32;
   localparam int TSIZE_WIDTH = 9;
   localparam int COLL_WIDTH  = 10;

   localparam logic [TSIZE_WIDTH-1:0] TABLE_SIZE_RESET = 9'd256;
   localparam logic [COLL_WIDTH-1:0]  COLL_MAX         = 10'd1023;
   localparam logic [7:0]             HASH_DIVISOR     = 8'd100;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic                  found;
      logic                  dropped;
      logic [COLL_WIDTH-1:0] collision_count;
   } res_flags_type;

endpackage

/* design/cht_if.sv */
// channel interfaces of the chained hash table unit
// depends on cht_pkg
interface cht_req_if #(parameter int PAYLOAD_WIDTH = cht_pkg::DEF_PAYLOAD_WIDTH);
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic signed [31:0]       key;
   logic [PAYLOAD_WIDTH-1:0] payload;
   modport source (output valid, func, key, payload, input ready);
   modport sink (input valid, func, key, payload, output ready);
endinterface

interface cht_rsp_if #(parameter int PAYLOAD_WIDTH = cht_pkg::DEF_PAYLOAD_WIDTH);
   logic                     valid;
   logic                     ready;
   logic                     found;
   logic [PAYLOAD_WIDTH-1:0] data_out;
   logic                     dropped;
   logic [9:0]               collision_count;
   modport source (output valid, found, data_out, dropped, collision_count, input ready);
   modport sink (input valid, found, data_out, dropped, collision_count, output ready);
endinterface

interface cht_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] table_size;
   modport source (output valid, table_size, input ready);
   modport sink (input valid, table_size, output ready);
endinterface

/* design/cht_hash.sv */
// iterative mid-square hash: square, divide by 100, reduce mod table size
// depends on cht_pkg
module cht_hash #(
   parameter int BUCKETS = cht_pkg::DEF_BUCKETS,
   parameter int MW      = $clog2(BUCKETS + 1),
   parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [cht_pkg::KEY_WIDTH-1:0]   key,
   input  logic [MW-1:0]                   modulus,
   output logic                            done,
   output logic [BW-1:0]                   bucket
);
   import cht_pkg::*;

   localparam int DIGITS = 4;
   localparam int STEPS  = 2 * KEY_WIDTH / DIGITS;
   localparam int CW     = $clog2(STEPS);

   typedef enum logic [2:0] {
      H_IDLE = 3'b001,
      H_MUL  = 3'b010,
      H_DIV  = 3'b100
   } hash_state_type;

   hash_state_type state_ff, state_in;
   logic [KEY_WIDTH-1:0]   mag_ff, mag_in;
   logic [2*KEY_WIDTH-1:0] sq_ff, sq_in;
   logic [6:0]             rem_ff, rem_in;
   logic [MW-1:0]          acc_ff, acc_in;
   logic [MW-1:0]          mod_ff, mod_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [BW-1:0]          bucket_ff, bucket_in;

   always_comb begin
      logic [7:0]  t8;
      logic        qbit;
      logic [MW:0] r2;
      logic [6:0]  rem_v;
      logic [MW-1:0] acc_v;
      state_in  = state_ff;
      mag_in    = mag_ff;
      sq_in     = sq_ff;
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      mod_in    = mod_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      bucket_in = bucket_ff;
      rem_v     = rem_ff;
      acc_v     = acc_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               mag_in   = key[KEY_WIDTH-1] ? (KEY_WIDTH'(0) - key) : key;
               mod_in   = modulus;
               state_in = H_MUL;
            end
         end
         H_MUL: begin
            sq_in    = mag_ff * mag_ff;
            rem_in   = '0;
            acc_in   = '0;
            cnt_in   = '0;
            state_in = H_DIV;
         end
         H_DIV: begin
            for (int i = 0; i < DIGITS; i++) begin
               t8   = {rem_v, sq_ff[2*KEY_WIDTH-1-i]};
               qbit = (t8 >= HASH_DIVISOR);
               if (qbit) begin
                  t8 = t8 - HASH_DIVISOR;
               end
               rem_v = t8[6:0];
               r2 = {acc_v, qbit};
               if (r2 >= {1'b0, mod_ff}) begin
                  r2 = r2 - {1'b0, mod_ff};
               end
               acc_v = r2[MW-1:0];
            end
            rem_in = rem_v;
            acc_in = acc_v;
            sq_in  = sq_ff << DIGITS;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(STEPS - 1)) begin
               done_in   = 1'b1;
               bucket_in = BW'(acc_v);
               state_in  = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      mag_ff    <= mag_in;
      sq_ff     <= sq_in;
      rem_ff    <= rem_in;
      acc_ff    <= acc_in;
      mod_ff    <= mod_in;
      bucket_ff <= bucket_in;
   end

   assign done   = done_ff;
   assign bucket = bucket_ff;

   a_done_from_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff) == H_DIV)
      else $error("hash done without division pass");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == H_DIV |-> rem_ff < HASH_DIVISOR[6:0])
      else $error("division remainder out of range");
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == H_DIV |-> acc_ff < mod_ff)
      else $error("modulus accumulator out of range");

endmodule

/* design/cht_engine.sv */
// table engine: bucket head and entry memories, insert and chain walk
// depends on cht_pkg and cht_hash
module cht_engine #(
   parameter int BUCKETS       = cht_pkg::DEF_BUCKETS,
   parameter int ENTRIES       = cht_pkg::DEF_ENTRIES,
   parameter int PAYLOAD_WIDTH = cht_pkg::DEF_PAYLOAD_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              ready,
   input  logic                              func,
   input  logic [cht_pkg::KEY_WIDTH-1:0]     key,
   input  logic [PAYLOAD_WIDTH-1:0]          payload,
   input  logic [cht_pkg::TSIZE_WIDTH-1:0]   table_size,
   output logic                              res_valid,
   input  logic                              res_ready,
   output cht_pkg::res_flags_type            res_flags,
   output logic [PAYLOAD_WIDTH-1:0]          res_data
);
   import cht_pkg::*;

   localparam int MW = $clog2(BUCKETS + 1);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int AW = $clog2(ENTRIES);
   localparam int LW = $clog2(ENTRIES + 1);
   localparam logic [LW-1:0] NIL = LW'(ENTRIES);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_HASH = 5'b00010,
      S_HEAD = 5'b00100,
      S_WALK = 5'b01000,
      S_DONE = 5'b10000
   } eng_state_type;

   eng_state_type state_ff, state_in;
   logic                     func_ff, func_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] payload_ff, payload_in;
   logic [BW-1:0]            bucket_ff, bucket_in;
   logic [LW-1:0]            used_ff, used_in;
   logic [COLL_WIDTH-1:0]    coll_ff, coll_in;
   logic                     found_ff, found_in;
   logic                     dropped_ff, dropped_in;
   logic [PAYLOAD_WIDTH-1:0] data_ff, data_in;
   logic [BUCKETS-1:0]       head_vld_ff, head_vld_in;

   logic [AW-1:0]            head_mem [BUCKETS];
   logic [AW-1:0]            head_rd_ff;
   logic                     head_we;
   logic [KEY_WIDTH-1:0]     ent_key_mem [ENTRIES];
   logic [PAYLOAD_WIDTH-1:0] ent_data_mem [ENTRIES];
   logic [LW-1:0]            ent_next_mem [ENTRIES];
   logic [KEY_WIDTH-1:0]     ent_key_rd_ff;
   logic [PAYLOAD_WIDTH-1:0] ent_data_rd_ff;
   logic [LW-1:0]            ent_next_rd_ff;
   logic [AW-1:0]            ent_raddr;
   logic                     ent_we;
   logic [LW-1:0]            head_link;

   logic                     hash_start;
   logic                     hash_done;
   logic [BW-1:0]            hash_bucket;
   logic [MW-1:0]            modulus;

   always_comb begin
      if (table_size == '0) begin
         modulus = MW'(1);
      end else if (32'(table_size) > BUCKETS) begin
         modulus = MW'(BUCKETS);
      end else begin
         modulus = MW'(table_size);
      end
   end

   cht_hash #(.BUCKETS(BUCKETS), .MW(MW), .BW(BW)) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (key),
      .modulus (modulus),
      .done    (hash_done),
      .bucket  (hash_bucket)
   );

   assign head_link = head_vld_ff[bucket_ff] ? LW'(head_rd_ff) : NIL;

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      payload_in  = payload_ff;
      bucket_in   = bucket_ff;
      used_in     = used_ff;
      coll_in     = coll_ff;
      found_in    = found_ff;
      dropped_in  = dropped_ff;
      data_in     = data_ff;
      head_vld_in = head_vld_ff;
      hash_start  = 1'b0;
      head_we     = 1'b0;
      ent_we      = 1'b0;
      ent_raddr   = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               hash_start = 1'b1;
               func_in    = func;
               key_in     = key;
               payload_in = payload;
               found_in   = 1'b0;
               dropped_in = 1'b0;
               data_in    = '0;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               bucket_in = hash_bucket;
               state_in  = S_HEAD;
            end
         end
         S_HEAD: begin
            if (func_ff == FUNC_INSERT) begin
               if (used_ff >= NIL) begin
                  dropped_in = 1'b1;
               end else begin
                  ent_we  = 1'b1;
                  head_we = 1'b1;
                  head_vld_in[bucket_ff] = 1'b1;
                  used_in = used_ff + LW'(1);
                  if (head_vld_ff[bucket_ff] && coll_ff < COLL_MAX) begin
                     coll_in = coll_ff + COLL_WIDTH'(1);
                  end
               end
               state_in = S_DONE;
            end else if (head_link == NIL) begin
               state_in = S_DONE;
            end else begin
               ent_raddr = head_link[AW-1:0];
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            if (ent_key_rd_ff == key_ff) begin
               found_in = 1'b1;
               data_in  = ent_data_rd_ff;
               state_in = S_DONE;
            end else if (ent_next_rd_ff == NIL) begin
               state_in = S_DONE;
            end else begin
               ent_raddr = ent_next_rd_ff[AW-1:0];
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[hash_bucket];
      if (head_we) begin
         head_mem[bucket_ff] <= used_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      ent_key_rd_ff  <= ent_key_mem[ent_raddr];
      ent_data_rd_ff <= ent_data_mem[ent_raddr];
      ent_next_rd_ff <= ent_next_mem[ent_raddr];
      if (ent_we) begin
         ent_key_mem[used_ff[AW-1:0]]  <= key_ff;
         ent_data_mem[used_ff[AW-1:0]] <= payload_ff;
         ent_next_mem[used_ff[AW-1:0]] <= head_link;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         used_ff     <= '0;
         coll_ff     <= '0;
         head_vld_ff <= '0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         coll_ff     <= coll_in;
         head_vld_ff <= head_vld_in;
      end
      func_ff    <= func_in;
      key_ff     <= key_in;
      payload_ff <= payload_in;
      bucket_ff  <= bucket_in;
      found_ff   <= found_in;
      dropped_ff <= dropped_in;
      data_ff    <= data_in;
   end

   assign ready                     = (state_ff == S_IDLE);
   assign res_valid                 = (state_ff == S_DONE);
   assign res_flags.found           = found_ff;
   assign res_flags.dropped         = dropped_ff;
   assign res_flags.collision_count = coll_ff;
   assign res_data                  = data_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= NIL)
      else $error("entry pool count past its size");
   a_insert_takes_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HEAD && func_ff == FUNC_INSERT && used_ff < NIL
      |=> used_ff == $past(used_ff) + LW'(1))
      else $error("insert did not take an entry");
   a_coll_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> coll_ff >= $past(coll_ff))
      else $error("collision count went down");
   a_found_only_lookup: assert property (@(posedge clock) disable iff (reset)
      res_valid && found_ff |-> func_ff == FUNC_LOOKUP && !dropped_ff)
      else $error("found flag on an insert");

endmodule

/* design/chained_hash_table_unit.sv */
// top level of the chained hash table unit: config register, engine, result register
// depends on cht_pkg, cht_if and cht_engine
// a request passes the hash, the bucket head read and, for a lookup, a walk over the chain entries visited
// one item at a time: a new item is taken only when the engine is back in idle, after the hash and chain walk
// reset: bucket heads empty, pool and collision count zero, table_size 256
module chained_hash_table_unit #(
   parameter int BUCKETS       = cht_pkg::DEF_BUCKETS,
   parameter int ENTRIES       = cht_pkg::DEF_ENTRIES,
   parameter int PAYLOAD_WIDTH = cht_pkg::DEF_PAYLOAD_WIDTH
) (
   input  logic  clock,
   input  logic  reset,
   cht_req_if.sink   req_ch,
   cht_rsp_if.source rsp_ch,
   cht_csr_if.sink   csr_ch
);
   import cht_pkg::*;

   logic [TSIZE_WIDTH-1:0]   tsize_ff, tsize_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   res_flags_type            rsp_flags_ff, rsp_flags_in;
   logic [PAYLOAD_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                     eng_ready;
   logic                     eng_res_valid;
   logic                     eng_res_ready;
   res_flags_type            eng_flags;
   logic [PAYLOAD_WIDTH-1:0] eng_data;

   cht_engine #(
      .BUCKETS       (BUCKETS),
      .ENTRIES       (ENTRIES),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (req_ch.valid),
      .ready      (eng_ready),
      .func       (req_ch.func),
      .key        (req_ch.key),
      .payload    (req_ch.payload),
      .table_size (tsize_ff),
      .res_valid  (eng_res_valid),
      .res_ready  (eng_res_ready),
      .res_flags  (eng_flags),
      .res_data   (eng_data)
   );

   assign eng_res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      tsize_in     = tsize_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_data_in  = rsp_data_ff;
      if (csr_ch.valid) begin
         tsize_in = csr_ch.table_size;
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_res_valid && eng_res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_flags_in = eng_flags;
         rsp_data_in  = eng_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff     <= TABLE_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tsize_ff     <= tsize_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_flags_ff <= rsp_flags_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ch.ready           = eng_ready;
   assign csr_ch.ready           = 1'b1;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.found           = rsp_flags_ff.found;
   assign rsp_ch.dropped         = rsp_flags_ff.dropped;
   assign rsp_ch.collision_count = rsp_flags_ff.collision_count;
   assign rsp_ch.data_out        = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending item overwritten");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |-> !eng_res_valid)
      else $error("item accepted while a result is pending");
   a_flags_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_flags_ff.found && rsp_flags_ff.dropped))
      else $error("found and dropped both set");

endmodule

/* tb/chained_hash_table_unit_tb.sv */
// testbench for chained_hash_table_unit: random and directed inserts and lookups
// checked against an in-bench model of the chained table; depends on cht_pkg, cht_if
`timescale 1ns / 1ps
module chained_hash_table_unit_tb;
   import cht_pkg::*;

   localparam int NBUCK = DEF_BUCKETS;
   localparam int NENT  = DEF_ENTRIES;
   localparam int WATCHDOG_LIMIT = 60000;

   typedef struct packed {
      logic        func;
      logic [31:0] key;
      logic [63:0] payload;
   } op_type;

   typedef struct packed {
      logic        found;
      logic [63:0] data_out;
      logic        dropped;
      logic [9:0]  collision_count;
   } res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #10 clock = ~clock;

   cht_req_if req_ch ();
   cht_rsp_if rsp_ch ();
   cht_csr_if csr_ch ();

   chained_hash_table_unit dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   op_type  pending_ops[$];
   res_type expected_res[$];

   // table model
   int unsigned m_size;
   int unsigned m_head[NBUCK];
   int unsigned m_next[NENT];
   logic [31:0] m_key[NENT];
   logic [63:0] m_data[NENT];
   int unsigned m_used;
   int unsigned m_coll;

   int unsigned errors = 0;
   int unsigned n_sent = 0, n_got = 0, n_found = 0, n_drop = 0;
   int unsigned idle_cycles = 0;
   bit hold_off = 1'b0;
   bit req_accepted = 1'b0;
   logic [31:0] used_keys[$];

   function automatic int unsigned bucket_for(logic [31:0] k);
      logic [31:0] mag;
      logic [63:0] sq;
      int unsigned ms;
      mag = k[31] ? (32'd0 - k) : k;
      sq = {32'd0, mag} * {32'd0, mag};
      ms = (m_size == 0) ? 1 : ((m_size > NBUCK) ? NBUCK : m_size);
      return int'((sq / 64'd100) % ms);
   endfunction

   function automatic res_type table_apply(op_type op);
      res_type r;
      int unsigned b, cur, steps;
      r = '0;
      b = bucket_for(op.key);
      if (op.func == FUNC_INSERT) begin
         if (m_used >= NENT) begin
            r.dropped = 1'b1;
         end else begin
            m_key[m_used] = op.key;
            m_data[m_used] = op.payload;
            if (m_head[b] != NENT && m_coll < 1023) m_coll++;
            m_next[m_used] = m_head[b];
            m_head[b] = m_used;
            m_used++;
         end
      end else begin
         cur = m_head[b];
         steps = 0;
         while (cur < NENT && steps < NENT) begin
            if (m_key[cur] == op.key) begin
               r.found = 1'b1;
               r.data_out = m_data[cur];
               break;
            end
            cur = m_next[cur];
            steps++;
         end
      end
      r.collision_count = m_coll[9:0];
      return r;
   endfunction

   // driver: bursts and gaps
   int unsigned burst_left = 0, gap_left = 0;
   initial begin
      req_ch.valid = 1'b0; req_ch.func = 1'b0; req_ch.key = '0; req_ch.payload = '0;
   end
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_accepted) begin
      end else if (gap_left > 0) begin
         gap_left--;
         req_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
         op_type op;
         op = pending_ops.pop_front();
         req_ch.valid <= 1'b1;
         req_ch.func <= op.func;
         req_ch.key <= op.key;
         req_ch.payload <= op.payload;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // receiver stall pattern
   int unsigned stall_phase = 0;
   initial rsp_ch.ready = 1'b0;
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset || hold_off) rsp_ch.ready <= 1'b0;
      else if (stall_phase[9]) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= (stall_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
   end

   // monitor
   always @(posedge clock) begin
      req_accepted <= req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            op_type op;
            op.func = req_ch.func; op.key = req_ch.key; op.payload = req_ch.payload;
            expected_res.push_back(table_apply(op));
            n_sent++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            res_type e;
            n_got++;
            if (expected_res.size() == 0) begin
               $error("result with no item pending");
               errors++;
            end else begin
               e = expected_res.pop_front();
               if (rsp_ch.found !== e.found) begin
                  $error("found exp %0d got %0d", e.found, rsp_ch.found); errors++;
               end
               if (rsp_ch.data_out !== e.data_out) begin
                  $error("data_out exp %h got %h", e.data_out, rsp_ch.data_out); errors++;
               end
               if (rsp_ch.dropped !== e.dropped) begin
                  $error("dropped exp %0d got %0d", e.dropped, rsp_ch.dropped); errors++;
               end
               if (rsp_ch.collision_count !== e.collision_count) begin
                  $error("collision_count exp %0d got %0d", e.collision_count,
                         rsp_ch.collision_count);
                  errors++;
               end
               n_found += e.found;
               n_drop += e.dropped;
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic push_op(logic f, logic [31:0] k, logic [63:0] p);
      op_type op;
      op.func = f; op.key = k; op.payload = p;
      pending_ops.push_back(op);
      if (f == FUNC_INSERT) used_keys.push_back(k);
   endtask

   task automatic wait_drained();
      while (pending_ops.size() > 0 || expected_res.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_size(logic [8:0] v);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.table_size <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      m_size = v;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // ins_pct: share of inserts in percent
   task automatic random_ops(int unsigned n, int unsigned ins_pct);
      logic [31:0] k;
      logic        f;
      for (int unsigned i = 0; i < n; i++) begin
         if (used_keys.size() > 0 && $urandom_range(0, 1))
            k = used_keys[$urandom_range(0, used_keys.size() - 1)];
         else if ($urandom_range(0, 3) == 0)
            k = $urandom_range(0, 300) - 150;
         else
            k = $urandom;
         f = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_LOOKUP;
         push_op(f, k, {$urandom, $urandom});
      end
   endtask

   initial begin
      csr_ch.valid = 1'b0;
      csr_ch.table_size = '0;
      m_size = 256;
      foreach (m_head[i]) m_head[i] = NENT;
      m_used = 0;
      m_coll = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, duplicates, missing keys
      push_op(FUNC_LOOKUP, 32'd5, '1);
      push_op(FUNC_INSERT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      push_op(FUNC_INSERT, 32'h7FFF_FFFF, 64'h0);
      push_op(FUNC_INSERT, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA);
      push_op(FUNC_INSERT, 32'd0, 64'hAAAA_5555_AAAA_5555);
      push_op(FUNC_INSERT, 32'd1, 64'h1);
      push_op(FUNC_INSERT, 32'd1, 64'h2);
      push_op(FUNC_LOOKUP, 32'd1, 64'h0);
      push_op(FUNC_LOOKUP, 32'h8000_0000, '1);
      push_op(FUNC_LOOKUP, 32'h7FFF_FFFF, 64'h0);
      push_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 64'h0);
      push_op(FUNC_LOOKUP, 32'd0, 64'h0);
      push_op(FUNC_LOOKUP, 32'd2, 64'h0);
      push_op(FUNC_LOOKUP, 32'hFFFF_FFFE, 64'h0);
      wait_drained();

      write_size(9'd0);
      push_op(FUNC_INSERT, 32'd12345, 64'h77);
      push_op(FUNC_LOOKUP, 32'd12345, 64'h0);
      push_op(FUNC_LOOKUP, 32'd1, 64'h0);
      random_ops(80, 50);
      wait_drained();

      write_size(9'd511);
      random_ops(250, 50);
      // long receiver hold-off while the sender keeps offering
      fork
         begin
            repeat (200) @(posedge clock);
            @(negedge clock);
            hold_off = 1'b1;
            repeat (600) @(posedge clock);
            @(negedge clock);
            hold_off = 1'b0;
         end
      join_none
      wait_drained();

      write_size(9'd1);
      random_ops(200, 75);
      wait_drained();
      write_size(9'd256);
      random_ops(250, 100);
      wait_drained();
      write_size(9'd37);
      random_ops(300, 100);
      wait_drained();
      // pool fills up here: the later inserts are dropped
      write_size(9'd257);
      random_ops(250, 100);
      wait_drained();

      $display("sent %0d items, %0d results, %0d lookups hit, %0d inserts dropped",
               n_sent, n_got, n_found, n_drop);
      $display("pool use %0d entries, %0d collisions", m_used, m_coll);
      if (errors == 0 && expected_res.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
